// ===== hdl/sida_pkg.sv =====
// package: shared types and constants for the signed integer to decimal text converter
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(DATA_W);
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_DIGS
  } sida_state_t;

endpackage
`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// top level: signed 32-bit integer to decimal ascii text, emitted character by character
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_value[31:0]      | in
//   result  | out_valid, out_stall, out_char_code[5:0], out_last | out
//
// each word is accepted, then takes 32 shift-and-add-three steps through the
// shared bcd step unit, a scan to find the leading digit, then loads its 1 to
// 11 characters into the output register
// synchronous active-low reset clears the sequencer and the output valid
// in_stall is high from accept until the final character is loaded
// out_stall holds the output register and pauses character loading
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sida_pkg::DATA_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [sida_pkg::CHAR_W-1:0]   out_char_code,
  output logic                               out_last
);

  sida_pkg::sida_state_t state_r, state_nxt;

  logic [sida_pkg::DATA_W-1:0] mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;
  logic [sida_pkg::BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [sida_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sida_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [sida_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [sida_pkg::BCD_W-1:0]  bcd_step;
  logic [sida_pkg::IDX_W-1:0]  msd_idx;
  logic [3:0]                  cur_digit;
  logic                        slot_free;

  sida_bcd_step u_step (
    .bcd_i (bcd_r),
    .bit_i (mag_r[sida_pkg::DATA_W-1]),
    .bcd_o (bcd_step)
  );

  // leading non-zero digit, units digit when all zero
  always_comb begin
    msd_idx = '0;
    for (int i = 1; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        msd_idx = sida_pkg::IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      sida_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[sida_pkg::DATA_W-1];
          mag_nxt   = in_value[sida_pkg::DATA_W-1] ? (sida_pkg::DATA_W'(0) - in_value)
                                                   : in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = sida_pkg::ST_CONV;
        end
      end
      sida_pkg::ST_CONV: begin
        bcd_nxt = bcd_step;
        mag_nxt = {mag_r[sida_pkg::DATA_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = sida_pkg::ST_SCAN;
        end
      end
      sida_pkg::ST_SCAN: begin
        idx_nxt   = msd_idx;
        state_nxt = neg_r ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGS;
      end
      sida_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sida_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = sida_pkg::ST_DIGS;
        end
      end
      sida_pkg::ST_DIGS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sida_pkg::CHAR_ZERO + {2'b00, cur_digit};
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = sida_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = sida_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sida_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != sida_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/sida_bcd_step.sv =====
// one shift-and-add-three step of the binary to bcd converter
`timescale 1ns / 1ps
`default_nettype none
module sida_bcd_step (
  input  wire logic [sida_pkg::BCD_W-1:0] bcd_i,
  input  wire logic                       bit_i,
  output logic      [sida_pkg::BCD_W-1:0] bcd_o
);

  logic [sida_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
  end

  assign bcd_o = {adj[sida_pkg::BCD_W-2:0], bit_i};

endmodule
`default_nettype wire
